>>> sv/hus_pkg.sv
// Package for the HTTP URL splitter: character codes, parse phase and part codes,
// widths, and the parse state and result record types.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package hus_pkg;

   localparam int MAX_LEN    = 4096;
   localparam int IDX_W      = $clog2(MAX_LEN);
   localparam int POS_W      = IDX_W + 1;
   localparam int FIELD_W    = 12;
   localparam int TRAIL_W    = 12;
   localparam int CALC_W     = (POS_W > TRAIL_W + 1) ? POS_W : TRAIL_W + 1;
   localparam int PREFIX_LEN = 7;
   localparam int PORT_W     = 16;
   localparam int MAX_DIGITS = 5;

   localparam logic [TRAIL_W-1:0] TRAIL_MAX = {TRAIL_W{1'b1}};

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_AT    = 8'h40;

   localparam logic [1:0] PH_LEAD   = 2'd0;
   localparam logic [1:0] PH_PREFIX = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   localparam logic [2:0] PT_USERINFO = 3'd0;
   localparam logic [2:0] PT_HOSTNAME = 3'd1;
   localparam logic [2:0] PT_PORT     = 3'd2;
   localparam logic [2:0] PT_PATH     = 3'd3;
   localparam logic [2:0] PT_FRAGMENT = 3'd4;
   localparam logic [2:0] PT_WS       = 3'd5;
   localparam logic [2:0] PT_ERROR    = 3'd6;

   localparam logic [PORT_W-1:0] DEFAULT_PORT_RESET = 16'd80;

   typedef struct packed {
      logic [1:0]         phase;
      logic [2:0]         prefix_idx;
      logic [2:0]         part;
      logic [POS_W-1:0]   position;
      logic [POS_W-1:0]   host_offset;
      logic [IDX_W-1:0]   host_length;
      logic [IDX_W-1:0]   port_offset;
      logic [2:0]         port_digits;
      logic [PORT_W-1:0]  port_number;
      logic [IDX_W-1:0]   path_offset;
      logic [IDX_W-1:0]   path_length;
      logic               prev_slash;
      logic [TRAIL_W-1:0] trail_spaces;
      logic               slash_before;
      logic               path_seen;
   } hus_state_type;

   typedef struct packed {
      logic               ok;
      logic [FIELD_W-1:0] host_start;
      logic [FIELD_W-1:0] host_len;
      logic               port_given;
      logic [FIELD_W-1:0] port_start;
      logic [2:0]         port_len;
      logic [PORT_W-1:0]  port_value;
      logic               path_present;
      logic [FIELD_W-1:0] path_start;
      logic [FIELD_W-1:0] path_len;
   } hus_result_type;

endpackage

`default_nettype wire

>>> sv/hus_if.sv
// Channel interfaces of the HTTP URL splitter: request, response and register write.
// Depends on hus_pkg for the field widths.
`default_nettype none

interface hus_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;
   modport source (output valid, output ch, output last, input ready);
   modport sink (input valid, input ch, input last, output ready);
endinterface

interface hus_rsp_if;
   import hus_pkg::*;
   logic               valid;
   logic               ready;
   logic               ok;
   logic [FIELD_W-1:0] host_start;
   logic [FIELD_W-1:0] host_len;
   logic               port_given;
   logic [FIELD_W-1:0] port_start;
   logic [2:0]         port_len;
   logic [PORT_W-1:0]  port_value;
   logic               path_present;
   logic [FIELD_W-1:0] path_start;
   logic [FIELD_W-1:0] path_len;
   modport source (output valid, output ok, output host_start, output host_len,
                   output port_given, output port_start, output port_len,
                   output port_value, output path_present, output path_start,
                   output path_len, input ready);
   modport sink (input valid, input ok, input host_start, input host_len,
                 input port_given, input port_start, input port_len,
                 input port_value, input path_present, input path_start,
                 input path_len, output ready);
endinterface

interface hus_csr_if;
   import hus_pkg::*;
   logic              valid;
   logic              ready;
   logic [PORT_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/hus_parser.sv
// Next-state and result logic of the URL splitter for one character.
// Purely combinational; depends on hus_pkg for codes and record types.
`default_nettype none

module hus_parser (
   input  hus_pkg::hus_state_type     state,
   input  logic [7:0]                 ch,
   input  logic                       last,
   input  logic [hus_pkg::PORT_W-1:0] default_port,
   output hus_pkg::hus_state_type     state_next,
   output hus_pkg::hus_result_type    result
);
   import hus_pkg::*;

   function automatic logic [7:0] scheme_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h68;
         3'd1:    c = 8'h74;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h70;
         3'd4:    c = CH_COLON;
         3'd5:    c = CH_SLASH;
         3'd6:    c = CH_SLASH;
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

   function automatic logic [IDX_W-1:0] trimmed(input logic [POS_W-1:0] end_pos,
                                                input logic [POS_W-1:0] start_pos,
                                                input logic [TRAIL_W-1:0] spaces,
                                                input logic slash);
      logic [CALC_W-1:0] len;
      logic [CALC_W-1:0] cut;
      logic [CALC_W-1:0] res;
      len = (end_pos > start_pos) ? CALC_W'(end_pos - start_pos) : '0;
      cut = CALC_W'(spaces) + CALC_W'(slash);
      res = (len > cut) ? len - cut : '0;
      return IDX_W'(res);
   endfunction

   hus_state_type     nxt;
   logic [POS_W-1:0]  pos;
   logic              hostish;
   logic              keep;
   logic              ok;
   logic [19:0]       port_times_ten;
   logic [3:0]        digit;

   always_comb begin
      nxt            = state;
      pos            = state.position;
      hostish        = (state.part == PT_USERINFO) || (state.part == PT_HOSTNAME);
      keep           = 1'b1;
      digit          = 4'(ch - CH_ZERO);
      port_times_ten = {1'b0, state.port_number, 3'b000} + {3'b000, state.port_number, 1'b0}
                       + 20'(digit);

      if (pos >= POS_W'(MAX_LEN)) begin
         if (state.phase != PH_DONE) begin
            nxt.part  = PT_ERROR;
            nxt.phase = PH_DONE;
         end
      end else begin
         nxt.position = pos + 1'b1;
         if (nxt.phase == PH_LEAD && ch != CH_SPACE) begin
            nxt.phase      = PH_PREFIX;
            nxt.prefix_idx = '0;
         end
         if (nxt.phase == PH_PREFIX) begin
            if (nxt.prefix_idx >= 3'(PREFIX_LEN) || ch != scheme_char(nxt.prefix_idx)) begin
               nxt.part  = PT_ERROR;
               nxt.phase = PH_DONE;
            end else begin
               nxt.prefix_idx = nxt.prefix_idx + 1'b1;
               if (nxt.prefix_idx == 3'(PREFIX_LEN)) begin
                  nxt.phase        = PH_BODY;
                  nxt.part         = PT_USERINFO;
                  nxt.host_offset  = pos + 1'b1;
                  nxt.trail_spaces = '0;
                  nxt.slash_before = 1'b1;
                  nxt.prev_slash   = 1'b1;
               end
            end
         end else if (nxt.phase == PH_BODY) begin
            if (ch == CH_NUL || (state.part == PT_WS && ch != CH_SPACE)) begin
               keep = 1'b0;
            end else if (ch == CH_AT) begin
               if (state.part == PT_USERINFO) begin
                  nxt.part        = PT_HOSTNAME;
                  nxt.host_offset = pos + 1'b1;
               end else if (state.part == PT_PORT) begin
                  keep = 1'b0;
               end
            end else if (ch == CH_COLON) begin
               if (hostish) begin
                  nxt.host_length = IDX_W'(pos - state.host_offset);
                  nxt.part        = PT_PORT;
               end else if (state.part == PT_PORT) begin
                  keep = 1'b0;
               end
            end else if (ch == CH_SLASH) begin
               if (hostish || state.part == PT_PORT) begin
                  if (hostish) begin
                     nxt.host_length = IDX_W'(pos - state.host_offset);
                  end
                  nxt.path_offset = IDX_W'(pos);
                  nxt.path_seen   = 1'b1;
                  nxt.part        = PT_PATH;
               end else if (state.part == PT_PATH && state.prev_slash) begin
                  keep = 1'b0;
               end
            end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
               if (state.part == PT_PORT) begin
                  if (state.port_digits >= 3'(MAX_DIGITS) || port_times_ten[19:16] != 4'd0) begin
                     keep = 1'b0;
                  end else begin
                     if (state.port_digits == 3'd0) begin
                        nxt.port_offset = IDX_W'(pos);
                     end
                     nxt.port_digits = state.port_digits + 1'b1;
                     nxt.port_number = port_times_ten[PORT_W-1:0];
                  end
               end
            end else if (ch == CH_HASH) begin
               if (hostish) begin
                  nxt.host_length = IDX_W'(pos - state.host_offset);
               end else if (state.part == PT_PATH) begin
                  nxt.path_length = IDX_W'(pos) - state.path_offset;
               end
               nxt.part  = PT_FRAGMENT;
               nxt.phase = PH_DONE;
            end else if (state.part == PT_PORT) begin
               if (ch == CH_SPACE) begin
                  nxt.part = PT_WS;
               end else begin
                  keep = 1'b0;
               end
            end

            if (!keep) begin
               nxt.part  = PT_ERROR;
               nxt.phase = PH_DONE;
            end else if (nxt.phase == PH_BODY) begin
               nxt.prev_slash = (ch == CH_SLASH);
               if (ch == CH_SPACE) begin
                  if (state.trail_spaces < TRAIL_MAX) begin
                     nxt.trail_spaces = state.trail_spaces + 1'b1;
                  end
               end else begin
                  nxt.trail_spaces = '0;
                  nxt.slash_before = (ch == CH_SLASH);
               end
            end
         end
      end

      ok = (nxt.phase == PH_BODY && nxt.part != PT_ERROR) ||
           (nxt.phase == PH_DONE && nxt.part == PT_FRAGMENT);
      if (ok && nxt.phase == PH_BODY) begin
         if (nxt.part == PT_USERINFO || nxt.part == PT_HOSTNAME) begin
            nxt.host_length = trimmed(nxt.position, nxt.host_offset,
                                      nxt.trail_spaces, nxt.slash_before);
         end else if (nxt.part == PT_PATH) begin
            nxt.path_length = trimmed(nxt.position, POS_W'(nxt.path_offset),
                                      nxt.trail_spaces, nxt.slash_before);
         end
      end

      result = '0;
      if (ok) begin
         result.ok           = 1'b1;
         result.host_start   = FIELD_W'(nxt.host_offset);
         result.host_len     = FIELD_W'(nxt.host_length);
         result.port_given   = (nxt.port_digits != 3'd0);
         result.port_start   = FIELD_W'(nxt.port_offset);
         result.port_len     = nxt.port_digits;
         result.port_value   = (nxt.port_digits != 3'd0) ? nxt.port_number : default_port;
         result.path_present = nxt.path_seen;
         result.path_start   = nxt.path_seen ? FIELD_W'(nxt.path_offset) : '0;
         result.path_len     = nxt.path_seen ? FIELD_W'(nxt.path_length) : '0;
      end

      if (last) begin
         nxt       = '0;
         nxt.phase = PH_LEAD;
         nxt.part  = PT_USERINFO;
      end

      state_next = nxt;
   end

endmodule

`default_nettype wire

>>> sv/http_url_splitter.sv
// Top level of the HTTP URL splitter: input register, parse state, response register
// and the default port register. Depends on hus_pkg, hus_if and hus_parser.
//
//   Channel   Direction  Moves
//   req_bus   in         one URL character and its last-of-URL mark per request
//   rsp_bus   out        one parse result per URL, on its last character
//   csr_bus   in         write of the default port register
//
// One character is taken every cycle unless a last character waits in the input register
// on a held response; a request is registered, then updates the parse state and, when it
// is the last of its URL, loads the response register, which offers the result. A waiting
// response holds only a last character in the input register; other characters keep
// flowing. Synchronous reset clears the parse state and sets the default port to 80.
`default_nettype none

module http_url_splitter (
   input  logic      clock,
   input  logic      reset,
   hus_req_if.sink   req_bus,
   hus_rsp_if.source rsp_bus,
   hus_csr_if.sink   csr_bus
);
   import hus_pkg::*;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [7:0]        in_ch_ff;
   logic              in_last_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   hus_result_type    out_ff;
   hus_result_type    step_result;
   hus_state_type     state_ff;
   hus_state_type     state_in;
   logic [PORT_W-1:0] default_port_ff;
   logic              step_fire;
   logic              req_take;

   hus_parser u_parser (
      .state        (state_ff),
      .ch           (in_ch_ff),
      .last         (in_last_ff),
      .default_port (default_port_ff),
      .state_next   (state_in),
      .result       (step_result)
   );

   assign step_fire       = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_bus.ready);
   assign req_bus.ready   = !in_valid_ff || step_fire;
   assign req_take        = req_bus.valid && req_bus.ready;
   assign in_valid_in     = req_take || (in_valid_ff && !step_fire);
   assign out_valid_in    = (step_fire && in_last_ff) || (out_valid_ff && !rsp_bus.ready);
   assign csr_bus.ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         state_ff        <= '0;
         default_port_ff <= DEFAULT_PORT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_fire) begin
            state_ff <= state_in;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            default_port_ff <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ch_ff   <= req_bus.ch;
         in_last_ff <= req_bus.last;
      end
      if (step_fire && in_last_ff) begin
         out_ff <= step_result;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.ok           = out_ff.ok;
   assign rsp_bus.host_start   = out_ff.host_start;
   assign rsp_bus.host_len     = out_ff.host_len;
   assign rsp_bus.port_given   = out_ff.port_given;
   assign rsp_bus.port_start   = out_ff.port_start;
   assign rsp_bus.port_len     = out_ff.port_len;
   assign rsp_bus.port_value   = out_ff.port_value;
   assign rsp_bus.path_present = out_ff.path_present;
   assign rsp_bus.path_start   = out_ff.path_start;
   assign rsp_bus.path_len     = out_ff.path_len;

endmodule

`default_nettype wire
